// ===== hdl/svc_pkg.sv =====
// -----------------------------------------------------------------------------
// svc_pkg: shared constants for the shift vector to colour unit
// Colour wheel table, CORDIC arctangent table and chain lengths.
// -----------------------------------------------------------------------------
package svc_pkg;

   localparam int WHEEL_SIZE   = 55;
   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 21;
   localparam int DIV_STEPS    = 8;

   localparam int RAMP_RY = 15;
   localparam int RAMP_YG = 6;
   localparam int RAMP_GC = 4;
   localparam int RAMP_CB = 11;
   localparam int RAMP_BM = 13;
   localparam int RAMP_MR = 6;
   localparam int FULL    = 255;

   typedef logic [17:0] atan_tab_type [CORDIC_STEPS];
   // round(atan(2^-i)/pi * 2^16)
   localparam atan_tab_type ATAN_TAB = '{
      18'd16384, 18'd9672, 18'd5110, 18'd2594, 18'd1302, 18'd652, 18'd326, 18'd163,
      18'd81, 18'd41, 18'd20, 18'd10, 18'd5, 18'd3, 18'd1, 18'd1
   };

   // wheel entry: {blue, green, red}
   typedef logic [23:0] wheel_tab_type [WHEEL_SIZE];

   function automatic wheel_tab_type build_wheel();
      wheel_tab_type tab;
      int            j;
      int            r;
      int            g;
      int            b;
      for (int k = 0; k < WHEEL_SIZE; k++) begin
         if (k < RAMP_RY) begin
            j = k;
            r = FULL; g = FULL * j / RAMP_RY; b = 0;
         end else if (k < RAMP_RY + RAMP_YG) begin
            j = k - RAMP_RY;
            r = FULL - FULL * j / RAMP_YG; g = FULL; b = 0;
         end else if (k < RAMP_RY + RAMP_YG + RAMP_GC) begin
            j = k - RAMP_RY - RAMP_YG;
            r = 0; g = FULL; b = FULL * j / RAMP_GC;
         end else if (k < RAMP_RY + RAMP_YG + RAMP_GC + RAMP_CB) begin
            j = k - RAMP_RY - RAMP_YG - RAMP_GC;
            r = 0; g = FULL - FULL * j / RAMP_CB; b = FULL;
         end else if (k < RAMP_RY + RAMP_YG + RAMP_GC + RAMP_CB + RAMP_BM) begin
            j = k - RAMP_RY - RAMP_YG - RAMP_GC - RAMP_CB;
            r = FULL * j / RAMP_BM; g = 0; b = FULL;
         end else begin
            j = k - RAMP_RY - RAMP_YG - RAMP_GC - RAMP_CB - RAMP_BM;
            r = FULL; g = 0; b = FULL - FULL * j / RAMP_MR;
         end
         tab[k] = {8'(b), 8'(g), 8'(r)};
      end
      return tab;
   endfunction

   localparam wheel_tab_type WHEEL_TAB = build_wheel();

endpackage

// ===== hdl/svc_cordic_cell.sv =====
// -----------------------------------------------------------------------------
// svc_cordic_cell: one vectoring CORDIC step
// Rotates (x,y) toward the x axis by atan(2^-STEP) and tracks the angle.
// -----------------------------------------------------------------------------
module svc_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] x_i,
   input  logic signed [31:0] y_i,
   input  logic signed [17:0] z_i,
   output logic signed [31:0] x_o,
   output logic signed [31:0] y_o,
   output logic signed [17:0] z_o
);

   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [17:0] z_ff, z_in;
   logic signed [31:0] xs;
   logic signed [31:0] ys;

   // floor shifts, direction from the sign of y
   always_comb begin
      xs = x_i >>> STEP;
      ys = y_i >>> STEP;
      if (!y_i[31]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + $signed(svc_pkg::ATAN_TAB[STEP]);
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - $signed(svc_pkg::ATAN_TAB[STEP]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

// ===== hdl/svc_sqrt_cell.sv =====
// -----------------------------------------------------------------------------
// svc_sqrt_cell: one digit of a restoring integer square root
// Brings down two radicand bits and decides one root bit.
// -----------------------------------------------------------------------------
module svc_sqrt_cell (
   input  logic        clock,
   input  logic        en,
   input  logic [41:0] rad_i,
   input  logic [22:0] rem_i,
   input  logic [20:0] root_i,
   output logic [41:0] rad_o,
   output logic [22:0] rem_o,
   output logic [20:0] root_o
);

   logic [41:0] rad_ff, rad_in;
   logic [22:0] rem_ff, rem_in;
   logic [20:0] root_ff, root_in;
   logic [24:0] acc;
   logic [24:0] trial;
   logic        ge;

   always_comb begin
      acc     = {rem_i, rad_i[41:40]};
      trial   = {2'b00, root_i, 2'b01};
      ge      = (acc >= trial);
      rem_in  = ge ? 23'(acc - trial) : acc[22:0];
      root_in = {root_i[19:0], ge};
      rad_in  = {rad_i[39:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// ===== hdl/svc_div_cell.sv =====
// -----------------------------------------------------------------------------
// svc_div_cell: one quotient bit of a restoring division
// Remainder stays below the divisor; one compare and subtract per cell.
// -----------------------------------------------------------------------------
module svc_div_cell (
   input  logic        clock,
   input  logic        en,
   input  logic [20:0] den,
   input  logic [20:0] rem_i,
   input  logic [7:0]  quo_i,
   output logic [20:0] rem_o,
   output logic [7:0]  quo_o
);

   logic [20:0] rem_ff, rem_in;
   logic [7:0]  quo_ff, quo_in;
   logic [21:0] r2;
   logic        ge;

   always_comb begin
      r2     = {rem_i, 1'b0};
      ge     = (r2 >= {1'b0, den});
      rem_in = ge ? 21'(r2 - {1'b0, den}) : r2[20:0];
      quo_in = {quo_i[6:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rem_o = rem_ff;
   assign quo_o = quo_ff;

endmodule

// ===== hdl/shift_vector_to_colour_unit.sv =====
// -----------------------------------------------------------------------------
// shift_vector_to_colour_unit: optical flow vector to wheel colour
// Maps a pixel shift (x,y) to RGB on a 55-entry colour wheel, faded to white
// by length over the programmed image diagonal.
// -----------------------------------------------------------------------------
// One item per clock unless the pipeline holds. The pipeline depth is set by
// the length path: a squared-length multiply, a 21-cell square root chain, a
// setup stage and an 8-cell divider chain; the 16-cell CORDIC angle chain and
// wheel interpolation run beside it. The whole pipeline holds only while a
// result waits and rsp_tready is low. Register 0 at address 0 is the image
// diagonal in pixels with 8 fraction bits.
module shift_vector_to_colour_unit #(
   parameter int MAX_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [12:0] shift_x, [25:13] shift_y
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LIM   = MAX_DIM - 1;
   localparam int DEPTH = 32;   // stages ahead of the output register
   localparam int CPOS  = 19;   // stage holding interpolated colour
   localparam int MPOS  = 31;   // stage holding the blend ratio

   typedef struct packed {
      logic xneg;
      logic yneg;
      logic mx_zero;
      logic my_zero;
   } quad_type;

   logic en;

   // ---------------- configuration register
   logic [20:0] max_norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_norm_ff <= 21'd1483008;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         max_norm_ff <= csr_pwdata[20:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {11'd0, max_norm_ff};

   // ---------------- pipeline control
   logic [DEPTH-1:0] vld_ff;
   logic             rsp_tvalid_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[DEPTH-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[DEPTH-1];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   // ---------------- stage 0: clamp, magnitudes, signs
   logic signed [15:0] sx, sy, cx, cy;
   logic [12:0]        mx_ff, mx_in, my_ff, my_in;
   quad_type           q0_ff, q0_in;

   always_comb begin
      sx = 16'(signed'(req_tdata[12:0]));
      sy = 16'(signed'(req_tdata[25:13]));
      cx = (sx > 16'(LIM)) ? 16'(LIM) : ((sx < -16'(LIM)) ? -16'(LIM) : sx);
      cy = (sy > 16'(LIM)) ? 16'(LIM) : ((sy < -16'(LIM)) ? -16'(LIM) : sy);
      mx_in = cx[15] ? 13'(-cx) : 13'(cx);
      my_in = cy[15] ? 13'(-cy) : 13'(cy);
      q0_in.xneg    = !cx[15];
      q0_in.yneg    = !cy[15];
      q0_in.mx_zero = (mx_in == 13'd0);
      q0_in.my_zero = (my_in == 13'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         q0_ff <= q0_in;
      end
   end

   // ---------------- angle chain
   logic signed [31:0] cx_w [svc_pkg::CORDIC_STEPS+1];
   logic signed [31:0] cy_w [svc_pkg::CORDIC_STEPS+1];
   logic signed [17:0] cz_w [svc_pkg::CORDIC_STEPS+1];
   quad_type           q_ff [1:svc_pkg::CORDIC_STEPS];

   assign cx_w[0] = {3'b000, mx_ff, 16'd0};
   assign cy_w[0] = {3'b000, my_ff, 16'd0};
   assign cz_w[0] = '0;

   for (genvar i = 0; i < svc_pkg::CORDIC_STEPS; i++) begin : g_cordic
      svc_cordic_cell #(.STEP(i)) u_cell (
         .clock (clock),
         .en    (en),
         .x_i   (cx_w[i]),
         .y_i   (cy_w[i]),
         .z_i   (cz_w[i]),
         .x_o   (cx_w[i+1]),
         .y_o   (cy_w[i+1]),
         .z_o   (cz_w[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff[1] <= q0_ff;
         for (int i = 2; i <= svc_pkg::CORDIC_STEPS; i++) begin
            q_ff[i] <= q_ff[i-1];
         end
      end
   end

   // ---------------- stage 17: angle to wheel position
   logic [15:0]        th;
   logic signed [17:0] ang;
   logic [17:0]        pos;
   logic [23:0]        tpos;
   logic [5:0]         k0_ff, k0_in, k1_ff, k1_in;
   logic [16:0]        f17_ff, f17_in;
   quad_type           qf;
   logic signed [17:0] zf;

   always_comb begin
      qf = q_ff[svc_pkg::CORDIC_STEPS];
      zf = cz_w[svc_pkg::CORDIC_STEPS];
      if (qf.my_zero) begin
         th = 16'd0;
      end else if (qf.mx_zero) begin
         th = 16'd32768;
      end else if (zf < 0) begin
         th = 16'd0;
      end else if (zf > 18'sd32768) begin
         th = 16'd32768;
      end else begin
         th = zf[15:0];
      end
      ang    = qf.xneg ? (18'sd65536 - $signed({2'b00, th})) : $signed({2'b00, th});
      ang    = qf.yneg ? -ang : ang;
      pos    = 18'(ang + 18'sd65536);
      tpos   = 24'(pos) * 24'(svc_pkg::WHEEL_SIZE - 1);
      k0_in  = tpos[22:17];
      k1_in  = (k0_in == 6'(svc_pkg::WHEEL_SIZE - 1)) ? k0_in : 6'(k0_in + 6'd1);
      f17_in = tpos[16:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k0_ff  <= k0_in;
         k1_ff  <= k1_in;
         f17_ff <= f17_in;
      end
   end

   // ---------------- stage 18: wheel lookup
   logic [23:0] w0_ff, w1_ff;
   logic [16:0] f18_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         w0_ff  <= svc_pkg::WHEEL_TAB[k0_ff];
         w1_ff  <= svc_pkg::WHEEL_TAB[k1_ff];
         f18_ff <= f17_ff;
      end
   end

   // ---------------- stage 19: interpolation per channel
   logic [23:0] col_in;
   logic [17:0] fw0;
   logic [25:0] acc [3];

   always_comb begin
      fw0 = 18'd131072 - {1'b0, f18_ff};
      for (int ch = 0; ch < 3; ch++) begin
         acc[ch] = 26'(w0_ff[ch*8 +: 8]) * 26'(fw0) + 26'(w1_ff[ch*8 +: 8]) * 26'(f18_ff)
                   + 26'd65536;
         col_in[ch*8 +: 8] = acc[ch][24:17];
      end
   end

   // colour delay line up to the ratio stage
   logic [23:0] col_ff [CPOS:MPOS];

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff[CPOS] <= col_in;
         for (int i = CPOS + 1; i <= MPOS; i++) begin
            col_ff[i] <= col_ff[i-1];
         end
      end
   end

   // ---------------- stage 1: squared length
   logic [25:0] sq_ff, sq_in;

   assign sq_in = 26'(26'(mx_ff) * 26'(mx_ff) + 26'(my_ff) * 26'(my_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
      end
   end

   // ---------------- square root chain, length in Q8
   logic [41:0] rad_w  [svc_pkg::SQRT_STEPS+1];
   logic [22:0] rem_w  [svc_pkg::SQRT_STEPS+1];
   logic [20:0] root_w [svc_pkg::SQRT_STEPS+1];

   assign rad_w[0]  = {sq_ff, 16'd0};
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;

   for (genvar j = 0; j < svc_pkg::SQRT_STEPS; j++) begin : g_sqrt
      svc_sqrt_cell u_cell (
         .clock  (clock),
         .en     (en),
         .rad_i  (rad_w[j]),
         .rem_i  (rem_w[j]),
         .root_i (root_w[j]),
         .rad_o  (rad_w[j+1]),
         .rem_o  (rem_w[j+1]),
         .root_o (root_w[j+1])
      );
   end

   // ---------------- stage 23: saturation check, divider setup
   logic [20:0] len;
   logic [20:0] dv_rem_ff;
   logic        sat_ff [0:svc_pkg::DIV_STEPS];

   assign len = root_w[svc_pkg::SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff <= len;
         sat_ff[0] <= (len >= max_norm_ff);
         for (int i = 1; i <= svc_pkg::DIV_STEPS; i++) begin
            sat_ff[i] <= sat_ff[i-1];
         end
      end
   end

   // ---------------- divider chain, ratio in Q8
   logic [20:0] drem_w [svc_pkg::DIV_STEPS+1];
   logic [7:0]  quo_w  [svc_pkg::DIV_STEPS+1];

   assign drem_w[0] = dv_rem_ff;
   assign quo_w[0]  = '0;

   for (genvar d = 0; d < svc_pkg::DIV_STEPS; d++) begin : g_div
      svc_div_cell u_cell (
         .clock (clock),
         .en    (en),
         .den   (max_norm_ff),
         .rem_i (drem_w[d]),
         .quo_i (quo_w[d]),
         .rem_o (drem_w[d+1]),
         .quo_o (quo_w[d+1])
      );
   end

   // ---------------- blend toward white, output register
   logic [8:0]  ratio;
   logic [23:0] rgb_in;
   logic [23:0] rsp_tdata_ff;
   logic [16:0] prod [3];
   logic [7:0]  dim  [3];

   always_comb begin
      ratio = sat_ff[svc_pkg::DIV_STEPS] ? 9'd256 : {1'b0, quo_w[svc_pkg::DIV_STEPS]};
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = 17'(8'd255 - col_ff[MPOS][ch*8 +: 8]) * 17'(ratio) + 17'd128;
         dim[ch]  = prod[ch][15:8];
         rgb_in[ch*8 +: 8] = 8'd255 - dim[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rgb_in;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;

endmodule
